@@ sv/trc_pkg.sv @@
`timescale 1ns / 1ps

package trc_pkg;

	// Reserve set geometry
	localparam int RESERVE_COUNT_DEF = 14;
	localparam int LANE_SLOTS = 16;
	localparam int RES_W = 16;
	localparam int MASK_W = 14;
	localparam int THR_W = 15;

	// Configuration port
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RISE_LIMIT = 4'd0,
		CFG_FALL_LIMIT = 4'd1,
		CFG_TOTAL_SAT = 4'd2,
		CFG_ACTIVE_MASK = 4'd3,
		CFG_THR_LOW = 4'd4,
		CFG_THR_HIGH = 4'd5,
		CFG_INCREMENT = 4'd6,
		CFG_TRANSITION = 4'd7
	} cfg_reg_t;

	localparam logic [15:0] TOTAL_SAT_RST = 16'd3200;
	localparam logic [MASK_W-1:0] ACTIVE_MASK_RST = 14'h3FFF;

	// Ratio scaling: products are clamped, then divided by 1000 with a reciprocal
	localparam int PROD_W = 24;
	localparam int QUOT_W = 14;
	localparam logic [PROD_W-1:0] PROD_CAP = 24'd9999999;
	localparam logic [24:0] RECIP_1000 = 25'd17179870;
	localparam int RECIP_1000_SHIFT = 34;

	// Step limits: 16-bit values divided by 100 with a reciprocal
	localparam int STEP_W = 10;
	localparam logic [16:0] RECIP_100 = 17'd83887;
	localparam int RECIP_100_SHIFT = 23;

	// Output caps
	localparam logic [12:0] PURGE_MAX = 13'd8000;
	localparam logic [12:0] AIR_MAX = 13'd8000;
	localparam logic [11:0] TOTAL_CAP = 12'd3200;
	localparam logic [14:0] MASKED_CAP = 15'd32000;
	localparam logic [14:0] INCREMENT_CAP = 15'd32000;
	localparam logic [8:0] TRANSITION_CAP = 9'd500;

	// Load strobes: an item moves into the named stage
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_s4;
	} pipe_ctl_t;

	// Settings seen by the merging stage
	typedef struct packed {
		logic [15:0] total_sat;
		logic [MASK_W-1:0] active_mask;
		logic [THR_W-1:0] thr_low;
		logic [THR_W-1:0] thr_high;
	} merge_cfg_t;

endpackage

@@ sv/trc_ratio_lane.sv @@
`timescale 1ns / 1ps

module trc_ratio_lane (
	input logic clk,
	input trc_pkg::pipe_ctl_t ctl,
	input logic [15:0] ratio,
	input logic signed [15:0] air,
	output logic [trc_pkg::QUOT_W-1:0] quot
);

	logic signed [32:0] prod;
	logic [trc_pkg::PROD_W-1:0] prod_sat;
	logic [trc_pkg::PROD_W-1:0] prod_s1;
	logic [48:0] scaled;
	logic [trc_pkg::QUOT_W-1:0] quot_s2;

	// Multiply ratio by the signed torque; only positive products matter downstream
	assign prod = $signed({1'b0, ratio}) * air;

	always_comb begin
		priority if (prod <= 0) begin
			prod_sat = '0;
		end else if (prod > $signed({9'd0, trc_pkg::PROD_CAP})) begin
			prod_sat = trc_pkg::PROD_CAP;
		end else begin
			prod_sat = prod[trc_pkg::PROD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			prod_s1 <= prod_sat;
		end
	end

	// Divide by 1000 through the reciprocal, exact for the clamped range
	assign scaled = {25'd0, prod_s1} * {24'd0, trc_pkg::RECIP_1000};

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			quot_s2 <= scaled[trc_pkg::RECIP_1000_SHIFT +: trc_pkg::QUOT_W];
		end
	end

	assign quot = quot_s2;

endmodule

@@ sv/trc_purge_slew.sv @@
`timescale 1ns / 1ps

module trc_purge_slew (
	input logic clk,
	input logic arst_n,
	input trc_pkg::pipe_ctl_t ctl,
	input logic [15:0] rise_limit,
	input logic signed [15:0] fall_limit,
	input logic [15:0] torque,
	input logic [trc_pkg::QUOT_W-1:0] quot,
	output logic [12:0] held
);

	logic [32:0] rise_prod;
	logic [32:0] fall_prod;
	logic [15:0] fall_mag;
	logic [trc_pkg::STEP_W-1:0] inc_q;
	logic [trc_pkg::STEP_W-1:0] dec_q;
	logic [12:0] held_q;
	logic seeded_q;
	logic [15:0] quot_w;
	logic [15:0] target;
	logic [13:0] up_sum;
	logic [15:0] up_val;
	logic [12:0] dec_w;
	logic [12:0] down_sub;
	logic [15:0] down_val;
	logic [15:0] next_val;
	logic [12:0] held_d;

	// Scale step limits by 1/100; a positive fall limit allows no decrease
	assign fall_mag = fall_limit[15] ? 16'(~fall_limit + 16'sd1) : 16'd0;
	assign rise_prod = {17'd0, rise_limit} * {16'd0, trc_pkg::RECIP_100};
	assign fall_prod = {17'd0, fall_mag} * {16'd0, trc_pkg::RECIP_100};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= '0;
			dec_q <= '0;
		end else begin
			inc_q <= rise_prod[trc_pkg::RECIP_100_SHIFT +: trc_pkg::STEP_W];
			dec_q <= fall_prod[trc_pkg::RECIP_100_SHIFT +: trc_pkg::STEP_W];
		end
	end

	// Target is the larger of requested torque and scaled ratio
	assign quot_w = {{(16 - trc_pkg::QUOT_W){1'b0}}, quot};
	assign target = (quot_w > torque) ? quot_w : torque;

	// Rise toward the target by at most one step
	assign up_sum = {1'b0, held_q} + {{(14 - trc_pkg::STEP_W){1'b0}}, inc_q};
	assign up_val = ({2'd0, up_sum} < target) ? {2'd0, up_sum} : target;

	// Fall toward the target by at most one step, floored at zero
	assign dec_w = {{(13 - trc_pkg::STEP_W){1'b0}}, dec_q};
	assign down_sub = (held_q > dec_w) ? (held_q - dec_w) : 13'd0;
	assign down_val = ({3'd0, down_sub} > target) ? {3'd0, down_sub} : target;

	always_comb begin
		priority if (!seeded_q) begin
			next_val = target;
		end else if (target > {3'd0, held_q}) begin
			next_val = up_val;
		end else begin
			next_val = down_val;
		end
		held_d = (next_val > {3'd0, trc_pkg::PURGE_MAX}) ? trc_pkg::PURGE_MAX : next_val[12:0];
	end

	// Hold the purge reserve between items; the first item seeds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			seeded_q <= 1'b0;
		end else if (ctl.load_s3) begin
			held_q <= held_d;
			seeded_q <= 1'b1;
		end
	end

	assign held = held_q;

endmodule

@@ sv/trc_merge.sv @@
`timescale 1ns / 1ps

module trc_merge #(
	parameter int RESERVE_COUNT = trc_pkg::RESERVE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input trc_pkg::pipe_ctl_t ctl,
	input trc_pkg::merge_cfg_t cfg,
	input logic [trc_pkg::RES_W-1:0] res [RESERVE_COUNT],
	output logic [11:0] total,
	output logic [14:0] masked,
	output logic active
);

	localparam int N = trc_pkg::LANE_SLOTS;

	logic [trc_pkg::RES_W-1:0] tot_node [1:2*N-1];
	logic [trc_pkg::RES_W-1:0] msk_node [1:2*N-1];
	logic [11:0] tot_cap;
	logic flag_q;

	// Lanes: gate each reserve into the total and masked trees
	for (genvar i = 0; i < N; i++) begin : g_lane
		if (i < RESERVE_COUNT) begin : g_used
			assign tot_node[N + i] = res[i];
			if (i < trc_pkg::MASK_W) begin : g_mask
				assign msk_node[N + i] = cfg.active_mask[i] ? res[i] : '0;
			end else begin : g_nomask
				assign msk_node[N + i] = '0;
			end
		end else begin : g_unused
			assign tot_node[N + i] = '0;
			assign msk_node[N + i] = '0;
		end
	end

	// Pairwise maximum tree
	for (genvar k = 1; k < N; k++) begin : g_tree
		assign tot_node[k] = (tot_node[2*k] > tot_node[2*k+1]) ? tot_node[2*k] : tot_node[2*k+1];
		assign msk_node[k] = (msk_node[2*k] > msk_node[2*k+1]) ? msk_node[2*k] : msk_node[2*k+1];
	end

	// Apply caps
	assign tot_cap = (tot_node[1] > {4'd0, trc_pkg::TOTAL_CAP}) ? trc_pkg::TOTAL_CAP
		: tot_node[1][11:0];
	assign total = ({4'd0, tot_cap} > cfg.total_sat) ? cfg.total_sat[11:0] : tot_cap;
	assign masked = (msk_node[1] > {1'b0, trc_pkg::MASKED_CAP}) ? trc_pkg::MASKED_CAP
		: msk_node[1][14:0];

	// Hysteresis: low threshold wins when the two overlap
	always_comb begin
		priority if (masked <= cfg.thr_low) begin
			active = 1'b0;
		end else if (masked >= cfg.thr_high) begin
			active = 1'b1;
		end else begin
			active = flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.load_s4) begin
			flag_q <= active;
		end
	end

endmodule

@@ sv/torque_reserve_coordinator_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid/in_ready    purge_ratio, air_torque_limit, purge_torque, basic_ratio,
//                                reserves_low, reserves_mid, reserves_high
// out       out_valid/out_ready  purge_reserve, air_compensation, total_reserve, masked_reserve,
//                                reserve_active, torque_increment, transition_time
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Takes one word per cycle unless a held out_ready has filled the pipe; each result is registered
// through stages 1 to 4 and offered from stage 4. Stage 3 closes the held purge loop through its
// slew logic, which sets that rate. Reset clears the held purge value, the seed mark and the
// active flag, and returns the settings to their defaults.
// Each stage advances when the next one is empty or moving, so bubbles collapse and
// words are still taken while a finished result waits on out_ready.

module torque_reserve_coordinator_core #(
	parameter int RESERVE_COUNT = trc_pkg::RESERVE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] purge_ratio,
	input logic signed [15:0] air_torque_limit,
	input logic [15:0] purge_torque,
	input logic [15:0] basic_ratio,
	input logic [63:0] reserves_low,
	input logic [63:0] reserves_mid,
	input logic [63:0] reserves_high,
	output logic out_valid,
	input logic out_ready,
	output logic [12:0] purge_reserve,
	output logic [12:0] air_compensation,
	output logic [11:0] total_reserve,
	output logic [14:0] masked_reserve,
	output logic reserve_active,
	output logic [14:0] torque_increment,
	output logic [8:0] transition_time,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [trc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [trc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Settings
	logic [15:0] rise_q;
	logic signed [15:0] fall_q;
	logic [15:0] sat_q;
	logic [trc_pkg::MASK_W-1:0] mask_q;
	logic [trc_pkg::THR_W-1:0] thr_low_q;
	logic [trc_pkg::THR_W-1:0] thr_high_q;
	logic [15:0] inc_set_q;
	logic [15:0] trans_q;

	// Pipeline
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	trc_pkg::pipe_ctl_t ctl;
	trc_pkg::merge_cfg_t mcfg;
	logic [15:0] torque_s1, torque_s2;
	logic [63:0] low_s1, mid_s1, high_s1;
	logic [63:0] low_s2, mid_s2, high_s2;
	logic [63:0] low_s3, mid_s3, high_s3;
	logic [12:0] air_s3;
	logic [trc_pkg::QUOT_W-1:0] quot_purge;
	logic [trc_pkg::QUOT_W-1:0] quot_basic;
	logic [12:0] air_d;
	logic [12:0] held;
	logic [trc_pkg::RES_W-1:0] res_v [RESERVE_COUNT];
	logic [11:0] total_d;
	logic [14:0] masked_d;
	logic active_d;
	logic [12:0] purge_s4, air_s4;
	logic [11:0] total_s4;
	logic [14:0] masked_s4;
	logic active_s4;
	logic [14:0] incr_s4;
	logic [8:0] trans_s4;

	// Pick the reserve at a given index of the full set
	function automatic logic [15:0] slot_value(input int idx, input logic [12:0] air,
		input logic [12:0] purge, input logic [63:0] lo, input logic [63:0] mid,
		input logic [63:0] hi);
		logic [15:0] v;
		unique case (idx)
			0: v = {3'd0, air};
			1: v = lo[15:0];
			2: v = lo[31:16];
			3: v = {3'd0, purge};
			4: v = lo[47:32];
			5: v = lo[63:48];
			6: v = mid[15:0];
			7: v = mid[31:16];
			8: v = mid[47:32];
			9: v = mid[63:48];
			10: v = hi[15:0];
			11: v = hi[31:16];
			12: v = hi[47:32];
			13: v = hi[63:48];
			default: v = '0;
		endcase
		return v;
	endfunction

	// Write settings
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			fall_q <= '0;
			sat_q <= trc_pkg::TOTAL_SAT_RST;
			mask_q <= trc_pkg::ACTIVE_MASK_RST;
			thr_low_q <= '0;
			thr_high_q <= '0;
			inc_set_q <= '0;
			trans_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (trc_pkg::cfg_reg_t'(cfg_index))
				trc_pkg::CFG_RISE_LIMIT: rise_q <= cfg_data;
				trc_pkg::CFG_FALL_LIMIT: fall_q <= $signed(cfg_data);
				trc_pkg::CFG_TOTAL_SAT: sat_q <= cfg_data;
				trc_pkg::CFG_ACTIVE_MASK: mask_q <= cfg_data[trc_pkg::MASK_W-1:0];
				trc_pkg::CFG_THR_LOW: thr_low_q <= cfg_data[trc_pkg::THR_W-1:0];
				trc_pkg::CFG_THR_HIGH: thr_high_q <= cfg_data[trc_pkg::THR_W-1:0];
				trc_pkg::CFG_INCREMENT: inc_set_q <= cfg_data;
				trc_pkg::CFG_TRANSITION: trans_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when the next one is empty or moving
	assign rdy4 = !valid_s4 || out_ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	assign ctl.load_s1 = in_valid && rdy1;
	assign ctl.load_s2 = valid_s1 && rdy2;
	assign ctl.load_s3 = valid_s2 && rdy3;
	assign ctl.load_s4 = valid_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// Carry the word payload down the pipe
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			torque_s1 <= purge_torque;
			low_s1 <= reserves_low;
			mid_s1 <= reserves_mid;
			high_s1 <= reserves_high;
		end
		if (ctl.load_s2) begin
			torque_s2 <= torque_s1;
			low_s2 <= low_s1;
			mid_s2 <= mid_s1;
			high_s2 <= high_s1;
		end
		if (ctl.load_s3) begin
			air_s3 <= air_d;
			low_s3 <= low_s2;
			mid_s3 <= mid_s2;
			high_s3 <= high_s2;
		end
	end

	// Ratio lanes: purge ratio and basic ratio
	trc_ratio_lane u_purge_lane (
		.clk (clk),
		.ctl (ctl),
		.ratio (purge_ratio),
		.air (air_torque_limit),
		.quot (quot_purge)
	);

	trc_ratio_lane u_basic_lane (
		.clk (clk),
		.ctl (ctl),
		.ratio (basic_ratio),
		.air (air_torque_limit),
		.quot (quot_basic)
	);

	assign air_d = (quot_basic > {{(trc_pkg::QUOT_W - 13){1'b0}}, trc_pkg::AIR_MAX})
		? trc_pkg::AIR_MAX : quot_basic[12:0];

	// Slew-limited purge reserve
	trc_purge_slew u_slew (
		.clk (clk),
		.arst_n (arst_n),
		.ctl (ctl),
		.rise_limit (rise_q),
		.fall_limit (fall_q),
		.torque (torque_s2),
		.quot (quot_purge),
		.held (held)
	);

	// Assemble the reserve set and merge
	for (genvar i = 0; i < RESERVE_COUNT; i++) begin : g_res
		assign res_v[i] = slot_value(i, air_s3, held, low_s3, mid_s3, high_s3);
	end

	assign mcfg.total_sat = sat_q;
	assign mcfg.active_mask = mask_q;
	assign mcfg.thr_low = thr_low_q;
	assign mcfg.thr_high = thr_high_q;

	trc_merge #(
		.RESERVE_COUNT (RESERVE_COUNT)
	) u_merge (
		.clk (clk),
		.arst_n (arst_n),
		.ctl (ctl),
		.cfg (mcfg),
		.res (res_v),
		.total (total_d),
		.masked (masked_d),
		.active (active_d)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			purge_s4 <= held;
			air_s4 <= air_s3;
			total_s4 <= total_d;
			masked_s4 <= masked_d;
			active_s4 <= active_d;
			incr_s4 <= ({1'b0, trc_pkg::INCREMENT_CAP} < inc_set_q)
				? trc_pkg::INCREMENT_CAP : inc_set_q[14:0];
			trans_s4 <= ({7'd0, trc_pkg::TRANSITION_CAP} < trans_q)
				? trc_pkg::TRANSITION_CAP : trans_q[8:0];
		end
	end

	assign out_valid = valid_s4;
	assign purge_reserve = purge_s4;
	assign air_compensation = air_s4;
	assign total_reserve = total_s4;
	assign masked_reserve = masked_s4;
	assign reserve_active = active_s4;
	assign torque_increment = incr_s4;
	assign transition_time = trans_s4;

	// Input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && out_valid && !out_ready))
		else $error("input stalled with a bubble in the pipeline");

	a_purge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (purge_reserve <= trc_pkg::PURGE_MAX))
		else $error("purge reserve above cap");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_reserve <= trc_pkg::TOTAL_CAP && {4'd0, total_reserve} <= sat_q))
		else $error("total reserve above cap");

	a_flag_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && masked_reserve <= thr_low_q) |-> !reserve_active)
		else $error("active flag set at or below low threshold");

	a_flag_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && masked_reserve > thr_low_q && masked_reserve >= thr_high_q)
		|-> reserve_active)
		else $error("active flag clear at or above high threshold");

endmodule

@@ dv/torque_reserve_coordinator_core_test.sv @@
`timescale 1ns / 1ps

module torque_reserve_coordinator_core_test;

	import trc_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1550;
	localparam int SETTING_PHASES = 8;
	localparam int DRAIN_CYCLES = 12;
	localparam longint RUN_LIMIT_NS = 64'd6_000_000;

	localparam int PURGE_CAP = 8000;
	localparam int AIR_CAP = 8000;
	localparam int TOTAL_CAP = 3200;
	localparam int MASKED_CAP = 32000;
	localparam int INCREMENT_CAP = 32000;
	localparam int TRANSITION_CAP = 500;
	localparam longint TARGET_CAP = 65535;
	localparam int RATIO_SCALE = 1000;
	localparam int STEP_SCALE = 100;

	// Indexes past the register list, which the block must ignore
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_TRANSITION + 1);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;

	typedef struct {
		logic [15:0] purge_ratio;
		logic signed [15:0] air_torque_limit;
		logic [15:0] purge_torque;
		logic [15:0] basic_ratio;
		logic [63:0] reserves_low;
		logic [63:0] reserves_mid;
		logic [63:0] reserves_high;
	} torque_word_t;

	typedef struct {
		logic [12:0] purge_reserve;
		logic [12:0] air_compensation;
		logic [11:0] total_reserve;
		logic [14:0] masked_reserve;
		logic reserve_active;
		logic [14:0] torque_increment;
		logic [8:0] transition_time;
	} reserve_result_t;

	typedef struct {
		bit is_setting;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [15:0] reg_data;
		torque_word_t word;
		bit known;
		reserve_result_t result;
	} stim_row_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [15:0] purge_ratio;
	logic signed [15:0] air_torque_limit;
	logic [15:0] purge_torque;
	logic [15:0] basic_ratio;
	logic [63:0] reserves_low;
	logic [63:0] reserves_mid;
	logic [63:0] reserves_high;
	logic out_valid;
	logic out_ready;
	logic [12:0] purge_reserve;
	logic [12:0] air_compensation;
	logic [11:0] total_reserve;
	logic [14:0] masked_reserve;
	logic reserve_active;
	logic [14:0] torque_increment;
	logic [8:0] transition_time;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the settings and the held state
	logic [15:0] rise_limit = '0;
	logic signed [15:0] fall_limit = '0;
	logic [15:0] total_sat = TOTAL_SAT_RST;
	logic [MASK_W-1:0] active_mask = ACTIVE_MASK_RST;
	logic [THR_W-1:0] thr_low = '0;
	logic [THR_W-1:0] thr_high = '0;
	logic [15:0] increment_set = '0;
	logic [15:0] transition_set = '0;
	logic [12:0] purge_held = '0;
	logic active_flag = 1'b0;
	logic purge_seeded = 1'b0;

	stim_row_t directed_rows[$];
	reserve_result_t awaited_results[$];
	int error_count = 0;
	int burst_left = 0;

	torque_reserve_coordinator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.purge_ratio(purge_ratio),
		.air_torque_limit(air_torque_limit),
		.purge_torque(purge_torque),
		.basic_ratio(basic_ratio),
		.reserves_low(reserves_low),
		.reserves_mid(reserves_mid),
		.reserves_high(reserves_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.purge_reserve(purge_reserve),
		.air_compensation(air_compensation),
		.total_reserve(total_reserve),
		.masked_reserve(masked_reserve),
		.reserve_active(reserve_active),
		.torque_increment(torque_increment),
		.transition_time(transition_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		error_count++;
		$display("%0t ERROR %s", $time, msg);
	endtask

	// Work out the result of one word and advance the held purge value and flag
	task automatic coordinate_reserves(input torque_word_t w, output reserve_result_t r);
		longint purge_prod;
		longint basic_prod;
		longint target;
		int held_now;
		int rise_step;
		int fall_step;
		int next_held;
		int air_comp;
		int total_max;
		int masked_max;
		int lane[16];
		int i;
		purge_prod = longint'(w.purge_ratio) * longint'(w.air_torque_limit) / RATIO_SCALE;
		target = longint'(w.purge_torque);
		if (purge_prod > target) begin
			target = purge_prod;
		end
		if (target > TARGET_CAP) begin
			target = TARGET_CAP;
		end
		held_now = int'(purge_held);
		// Seed on the first word after reset, slew on every later one
		if (!purge_seeded) begin
			next_held = int'(target);
			purge_seeded = 1'b1;
		end else begin
			rise_step = int'(rise_limit) / STEP_SCALE;
			fall_step = -int'(fall_limit) / STEP_SCALE;
			if (fall_step < 0) begin
				fall_step = 0;
			end
			if (target > held_now) begin
				next_held = held_now + rise_step;
				if (next_held > target) begin
					next_held = int'(target);
				end
			end else begin
				next_held = held_now > fall_step ? held_now - fall_step : 0;
				if (next_held < target) begin
					next_held = int'(target);
				end
			end
		end
		if (next_held > PURGE_CAP) begin
			next_held = PURGE_CAP;
		end
		purge_held = next_held[12:0];

		basic_prod = longint'(w.basic_ratio) * longint'(w.air_torque_limit) / RATIO_SCALE;
		if (basic_prod < 0) begin
			air_comp = 0;
		end else if (basic_prod > AIR_CAP) begin
			air_comp = AIR_CAP;
		end else begin
			air_comp = int'(basic_prod);
		end

		// Place the two derived values next to the twelve external reserves
		for (i = 0; i < LANE_SLOTS; i++) begin
			lane[i] = 0;
		end
		lane[0] = air_comp;
		lane[1] = int'(w.reserves_low[15:0]);
		lane[2] = int'(w.reserves_low[31:16]);
		lane[3] = next_held;
		lane[4] = int'(w.reserves_low[47:32]);
		lane[5] = int'(w.reserves_low[63:48]);
		for (i = 0; i < 4; i++) begin
			lane[6 + i] = int'(w.reserves_mid[16 * i +: 16]);
			lane[10 + i] = int'(w.reserves_high[16 * i +: 16]);
		end

		total_max = 0;
		masked_max = 0;
		for (i = 0; i < RESERVE_COUNT_DEF; i++) begin
			if (lane[i] > total_max) begin
				total_max = lane[i];
			end
			if (active_mask[i] && lane[i] > masked_max) begin
				masked_max = lane[i];
			end
		end
		if (total_max > TOTAL_CAP) begin
			total_max = TOTAL_CAP;
		end
		if (total_max > int'(total_sat)) begin
			total_max = int'(total_sat);
		end
		if (masked_max > MASKED_CAP) begin
			masked_max = MASKED_CAP;
		end

		// Low threshold is tested first, so it wins when the two overlap
		if (masked_max <= int'(thr_low)) begin
			active_flag = 1'b0;
		end else if (masked_max >= int'(thr_high)) begin
			active_flag = 1'b1;
		end

		r.purge_reserve = purge_held;
		r.air_compensation = air_comp[12:0];
		r.total_reserve = total_max[11:0];
		r.masked_reserve = masked_max[14:0];
		r.reserve_active = active_flag;
		r.torque_increment = int'(increment_set) > INCREMENT_CAP ?
			INCREMENT_CAP[14:0] : increment_set[14:0];
		r.transition_time = int'(transition_set) > TRANSITION_CAP ?
			TRANSITION_CAP[8:0] : transition_set[8:0];
	endtask

	// Offer one word and hold it until taken; valid stays high for the caller
	task automatic send_word(input torque_word_t w, input bit known,
		input reserve_result_t literal_result);
		reserve_result_t predicted;
		purge_ratio <= w.purge_ratio;
		air_torque_limit <= w.air_torque_limit;
		purge_torque <= w.purge_torque;
		basic_ratio <= w.basic_ratio;
		reserves_low <= w.reserves_low;
		reserves_mid <= w.reserves_mid;
		reserves_high <= w.reserves_high;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		coordinate_reserves(w, predicted);
		awaited_results.push_back(known ? literal_result : predicted);
	endtask

	// Keep offering through a burst, then drop valid for a random gap
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// Stop offering and wait until every awaited result has come out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// Write one register; cfg_valid stays high for the caller to drop
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_RISE_LIMIT: rise_limit = data;
			CFG_FALL_LIMIT: fall_limit = data;
			CFG_TOTAL_SAT: total_sat = data;
			CFG_ACTIVE_MASK: active_mask = data[MASK_W-1:0];
			CFG_THR_LOW: thr_low = data[THR_W-1:0];
			CFG_THR_HIGH: thr_high = data[THR_W-1:0];
			CFG_INCREMENT: increment_set = data;
			CFG_TRANSITION: transition_set = data;
			default: ;
		endcase
	endtask

	task automatic add_setting(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		stim_row_t row;
		row = '{default: '0};
		row.is_setting = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		directed_rows.push_back(row);
	endtask

	task automatic add_item(input torque_word_t w);
		stim_row_t row;
		row = '{default: '0};
		row.word = w;
		directed_rows.push_back(row);
	endtask

	task automatic add_known(input torque_word_t w, input reserve_result_t r);
		stim_row_t row;
		row = '{default: '0};
		row.word = w;
		row.known = 1'b1;
		row.result = r;
		directed_rows.push_back(row);
	endtask

	function automatic logic [15:0] random_lane();
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: v = 16'($urandom_range(0, 4000));
			3: v = 16'($urandom_range(0, 12000));
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [15:0] random_ratio();
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: v = 16'($urandom_range(0, 2000));
			3: v = 16'($urandom_range(900, 1100));
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Phase 0 clears every setting, phase 1 sets every bit, later phases draw at random
	function automatic logic [15:0] setting_value(input int phase, input logic [15:0] drawn);
		if (phase == 0) begin
			return '0;
		end else if (phase == 1) begin
			return '1;
		end
		return drawn;
	endfunction

	// Check each result word against the oldest awaited one
	always @(posedge clk) begin : result_check
		reserve_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				flag_error("result word with nothing awaited");
			end else begin
				want = awaited_results.pop_front();
				if (purge_reserve !== want.purge_reserve) begin
					flag_error($sformatf("purge_reserve %0d, expected %0d",
						purge_reserve, want.purge_reserve));
				end
				if (air_compensation !== want.air_compensation) begin
					flag_error($sformatf("air_compensation %0d, expected %0d",
						air_compensation, want.air_compensation));
				end
				if (total_reserve !== want.total_reserve) begin
					flag_error($sformatf("total_reserve %0d, expected %0d",
						total_reserve, want.total_reserve));
				end
				if (masked_reserve !== want.masked_reserve) begin
					flag_error($sformatf("masked_reserve %0d, expected %0d",
						masked_reserve, want.masked_reserve));
				end
				if (reserve_active !== want.reserve_active) begin
					flag_error($sformatf("reserve_active %0b, expected %0b",
						reserve_active, want.reserve_active));
				end
				if (torque_increment !== want.torque_increment) begin
					flag_error($sformatf("torque_increment %0d, expected %0d",
						torque_increment, want.torque_increment));
				end
				if (transition_time !== want.transition_time) begin
					flag_error($sformatf("transition_time %0d, expected %0d",
						transition_time, want.transition_time));
				end
			end
		end
	end

	// Cycle the receiver through open, random, sparse and long hold-off stretches
	initial begin : receiver
		rx_mode_t mode;
		int span;
		mode = RX_OPEN;
		out_ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			span = $urandom_range(20, 80);
			case (mode)
				RX_OPEN: repeat (span) begin
					out_ready <= 1'b1;
					@(posedge clk);
				end
				RX_RANDOM: repeat (span) begin
					out_ready <= ($urandom_range(0, 1) == 1);
					@(posedge clk);
				end
				RX_SPARSE: repeat (span) begin
					out_ready <= ($urandom_range(0, 3) == 0);
					@(posedge clk);
				end
				default: begin
					// Hold off long enough for the block to fill and stall its input
					out_ready <= 1'b0;
					span = $urandom_range(40, 100);
					repeat (span) @(posedge clk);
				end
			endcase
			mode = mode.next();
		end
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		torque_word_t w;
		reserve_result_t none;
		logic [15:0] low_pick;
		logic [15:0] high_pick;
		int phase;
		int k;
		int j;
		none = '{default: '0};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		purge_ratio <= '0;
		air_torque_limit <= '0;
		purge_torque <= '0;
		basic_ratio <= '0;
		reserves_low <= '0;
		reserves_mid <= '0;
		reserves_high <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		// Reset settings: seed beyond the purge cap, then both extremes of air torque
		add_known('{16'd0, 16'sd0, 16'd9000, 16'd0, 64'd0, 64'd0, 64'd0},
			'{13'd8000, 13'd0, 12'd3200, 15'd8000, 1'b1, 15'd0, 9'd0});
		add_known('{16'hFFFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, '1, '1, '1},
			'{13'd8000, 13'd8000, 12'd3200, 15'd32000, 1'b1, 15'd0, 9'd0});
		add_item('{16'hFFFF, 16'sh8000, 16'd0, 16'hFFFF, 64'd0, 64'd0, 64'd0});
		// Air compensation exactly at its cap and one above
		add_item('{16'd1000, 16'sd8000, 16'd0, 16'd1000, 64'd0, 64'd0, 64'd0});
		add_item('{16'd0, 16'sd8001, 16'd0, 16'd1000, 64'd0, 64'd0, 64'd0});

		// Largest slew steps, nothing selected, zero saturation, caps on the settings
		add_setting(CFG_RISE_LIMIT, 16'hFFFF);
		add_setting(CFG_FALL_LIMIT, 16'h8000);
		add_setting(CFG_TOTAL_SAT, 16'd0);
		add_setting(CFG_ACTIVE_MASK, 16'd0);
		add_setting(CFG_THR_LOW, 16'd100);
		add_setting(CFG_THR_HIGH, 16'd200);
		add_setting(CFG_INCREMENT, 16'hFFFF);
		add_setting(CFG_TRANSITION, 16'hFFFF);
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, 64'hFFFF});
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, 64'd0});
		add_item('{16'd0, 16'sd0, 16'hFFFF, 16'd0, 64'd0, 64'hFFFF, 64'd0});

		// A positive fall limit gives no decrease; thresholds overlap; one above each cap
		add_setting(CFG_RISE_LIMIT, 16'd1234);
		add_setting(CFG_FALL_LIMIT, 16'h7FFF);
		add_setting(CFG_TOTAL_SAT, 16'hFFFF);
		add_setting(CFG_ACTIVE_MASK, 16'h0009);
		add_setting(CFG_THR_LOW, 16'd5000);
		add_setting(CFG_THR_HIGH, 16'd3000);
		add_setting(CFG_INCREMENT, 16'd32001);
		add_setting(CFG_TRANSITION, 16'd501);
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, 64'd0});
		add_item('{16'd0, 16'sd0, 16'd9000, 16'd0, 64'd0, 64'd0, 64'd0});
		// Negative products truncate toward zero
		add_item('{16'd3, -16'sd1, 16'd0, 16'd3, 64'd0, 64'd0, 64'd0});
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, {16'd32000, 48'd0}});

		// Hysteresis on the last reserve alone
		add_setting(CFG_ACTIVE_MASK, 16'h2000);
		add_setting(CFG_THR_LOW, 16'd1000);
		add_setting(CFG_THR_HIGH, 16'd2000);
		add_setting(CFG_TOTAL_SAT, 16'd1234);
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, {16'd1500, 48'd0}});
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, {16'd2000, 48'd0}});
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, {16'd1500, 48'd0}});
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'd0, {16'd1000, 48'd0}});
		add_item('{16'd0, 16'sd0, 16'd0, 16'd0, 64'd0, 64'hFFFF, 64'd0});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; settings wait for the block to drain
		for (k = 0; k < directed_rows.size(); k++) begin
			if (directed_rows[k].is_setting) begin
				settle_block();
				write_register(directed_rows[k].reg_idx, directed_rows[k].reg_data);
				if (k + 1 == directed_rows.size() || !directed_rows[k + 1].is_setting) begin
					cfg_valid <= 1'b0;
				end
			end else begin
				send_word(directed_rows[k].word, directed_rows[k].known,
					directed_rows[k].result);
				pace_sender();
			end
		end

		for (phase = 0; phase < SETTING_PHASES; phase++) begin
			settle_block();
			// Thresholds mostly near the reserve values, sometimes anywhere
			low_pick = 16'($urandom_range(0, 8000));
			high_pick = 16'(low_pick + $urandom_range(0, 8000));
			if ($urandom_range(0, 3) == 0) begin
				low_pick = 16'($urandom);
				high_pick = 16'($urandom);
			end
			write_register(CFG_RISE_LIMIT, setting_value(phase, 16'($urandom)));
			write_register(CFG_FALL_LIMIT, setting_value(phase, 16'($urandom)));
			write_register(CFG_TOTAL_SAT, setting_value(phase, 16'($urandom)));
			write_register(CFG_ACTIVE_MASK, setting_value(phase, 16'($urandom)));
			write_register(CFG_THR_LOW, setting_value(phase, low_pick));
			write_register(CFG_THR_HIGH, setting_value(phase, high_pick));
			write_register(CFG_INCREMENT, setting_value(phase, 16'($urandom)));
			write_register(CFG_TRANSITION, setting_value(phase, 16'($urandom)));
			write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
				16'($urandom));
			cfg_valid <= 1'b0;

			for (k = 0; k < RANDOM_ITEMS / SETTING_PHASES; k++) begin
				w.purge_ratio = random_ratio();
				w.basic_ratio = random_ratio();
				case ($urandom_range(0, 5))
					0: w.air_torque_limit = 16'sh8000;
					1: w.air_torque_limit = 16'sh7FFF;
					2: w.air_torque_limit = 16'($urandom_range(0, 12000));
					3: w.air_torque_limit = 16'($urandom);
					default: w.air_torque_limit = 16'($urandom_range(0, 9000));
				endcase
				case ($urandom_range(0, 5))
					0: w.purge_torque = '0;
					1: w.purge_torque = '1;
					2: w.purge_torque = 16'($urandom);
					default: w.purge_torque = 16'($urandom_range(0, 9500));
				endcase
				for (j = 0; j < 4; j++) begin
					w.reserves_low[16 * j +: 16] = random_lane();
					w.reserves_mid[16 * j +: 16] = random_lane();
					w.reserves_high[16 * j +: 16] = random_lane();
				end
				send_word(w, 1'b0, none);
				pace_sender();
			end
		end

		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
